// ===== rtl/psc_pkg.sv =====
package psc_pkg;

	localparam int TIME_W     = 32;
	localparam int CFG_W      = 16;
	localparam int OUT_W      = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int COUNT_BITS_DEF = 8;

	localparam logic [CFG_W-1:0] RST_MIN_PULSE   = 16'd50;
	localparam logic [CFG_W-1:0] RST_MAX_PULSE   = 16'd300;
	localparam logic [CFG_W-1:0] RST_SER_TIMEOUT = 16'd2500;

	// The match counter stops here; reaching it confirms the count.
	localparam logic [1:0] MATCH_SAT = 2'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_PULSE   = 2'd0,
		REG_MAX_PULSE   = 2'd1,
		REG_SER_TIMEOUT = 2'd2
	} cfg_reg_e;

	typedef struct packed {
		logic [CFG_W-1:0] min_pulse_ms;
		logic [CFG_W-1:0] max_pulse_ms;
		logic [CFG_W-1:0] series_timeout_ms;
	} psc_cfg_t;

	typedef struct packed {
		logic              level;
		logic [TIME_W-1:0] time_ms;
		logic              clear;
	} psc_item_t;

	typedef struct packed {
		logic [OUT_W-1:0] confirmed_preset;
		logic             series_ended;
		logic [OUT_W-1:0] series_count;
	} psc_result_t;

endpackage

// ===== rtl/psc_cfg.sv =====
module psc_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psc_pkg::CFG_W-1:0]     cfg_data,
	output psc_pkg::psc_cfg_t             cfg
);
	import psc_pkg::*;

	psc_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Writes to an index outside the register list are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pulse_ms      <= RST_MIN_PULSE;
			cfg_q.max_pulse_ms      <= RST_MAX_PULSE;
			cfg_q.series_timeout_ms <= RST_SER_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MIN_PULSE:   cfg_q.min_pulse_ms      <= cfg_data;
				REG_MAX_PULSE:   cfg_q.max_pulse_ms      <= cfg_data;
				REG_SER_TIMEOUT: cfg_q.series_timeout_ms <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/psc_core.sv =====
module psc_core #(
	parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  psc_pkg::psc_item_t   item,
	input  psc_pkg::psc_cfg_t    cfg,
	output psc_pkg::psc_result_t result
);
	import psc_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam int EXT_W = (COUNT_BITS > OUT_W) ? COUNT_BITS : OUT_W;

	logic                  in_series_q, in_series_n;
	logic                  prev_level_q, prev_level_n;
	logic                  pulse_active_q, pulse_active_n;
	logic [TIME_W-1:0]     pulse_start_q, pulse_start_n;
	logic [TIME_W-1:0]     last_end_q, last_end_n;
	logic [COUNT_BITS-1:0] cur_cnt_q, cur_cnt_n;
	logic [COUNT_BITS-1:0] prev_cnt_q, prev_cnt_n;
	logic [1:0]            match_q, match_n;
	logic [COUNT_BITS-1:0] conf_q, conf_n;

	logic [TIME_W-1:0]     width;
	logic [TIME_W-1:0]     idle_time;
	logic                  width_ok;
	logic                  valid_end;
	logic                  ended;
	logic [1:0]            match_inc;
	logic [EXT_W-1:0]      cnt_ext;
	logic [EXT_W-1:0]      conf_ext;

	assign width    = item.time_ms - pulse_start_q;
	assign width_ok = (width >= TIME_W'(cfg.min_pulse_ms)) &&
	                  (width <= TIME_W'(cfg.max_pulse_ms));
	assign match_inc = (match_q < MATCH_SAT) ? 2'(match_q + 2'd1) : match_q;

	always_comb begin
		in_series_n    = in_series_q;
		prev_level_n   = prev_level_q;
		pulse_active_n = pulse_active_q;
		pulse_start_n  = pulse_start_q;
		last_end_n     = last_end_q;
		cur_cnt_n      = cur_cnt_q;
		prev_cnt_n     = prev_cnt_q;
		match_n        = match_q;
		conf_n         = conf_q;
		valid_end      = 1'b0;
		ended          = 1'b0;
		idle_time      = item.time_ms - last_end_q;

		if (item.clear) begin
			in_series_n    = 1'b0;
			cur_cnt_n      = '0;
			prev_cnt_n     = '0;
			match_n        = '0;
			conf_n         = '0;
			pulse_active_n = 1'b0;
			prev_level_n   = item.level;
		end else begin
			if (item.level != prev_level_q) begin
				if (!item.level) begin
					pulse_active_n = 1'b1;
					pulse_start_n  = item.time_ms;
				end else if (pulse_active_q) begin
					if (width_ok) begin
						valid_end   = 1'b1;
						in_series_n = 1'b1;
						if (!in_series_q) begin
							cur_cnt_n = COUNT_BITS'(1);
						end else if (cur_cnt_q != COUNT_MAX) begin
							cur_cnt_n = cur_cnt_q + COUNT_BITS'(1);
						end
						last_end_n = item.time_ms;
					end else begin
						in_series_n = 1'b0;
						cur_cnt_n   = '0;
					end
					pulse_active_n = 1'b0;
				end
				prev_level_n = item.level;
			end
			// A pulse that ended validly on this sample leaves no idle time.
			if (valid_end) begin
				idle_time = '0;
			end
			if (in_series_n && !pulse_active_n &&
			    idle_time > TIME_W'(cfg.series_timeout_ms)) begin
				ended = 1'b1;
				if (prev_cnt_q == '0 || cur_cnt_n != prev_cnt_q) begin
					prev_cnt_n = cur_cnt_n;
					match_n    = 2'd1;
				end else begin
					match_n = match_inc;
					if (match_inc >= MATCH_SAT) begin
						conf_n = cur_cnt_n;
					end
				end
				in_series_n = 1'b0;
				cur_cnt_n   = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_series_q    <= 1'b0;
			prev_level_q   <= 1'b1;
			pulse_active_q <= 1'b0;
			pulse_start_q  <= '0;
			last_end_q     <= '0;
			cur_cnt_q      <= '0;
			prev_cnt_q     <= '0;
			match_q        <= '0;
			conf_q         <= '0;
		end else if (fire) begin
			in_series_q    <= in_series_n;
			prev_level_q   <= prev_level_n;
			pulse_active_q <= pulse_active_n;
			pulse_start_q  <= pulse_start_n;
			last_end_q     <= last_end_n;
			cur_cnt_q      <= cur_cnt_n;
			prev_cnt_q     <= prev_cnt_n;
			match_q        <= match_n;
			conf_q         <= conf_n;
		end
	end

	assign cnt_ext  = EXT_W'(cur_cnt_n);
	assign conf_ext = EXT_W'(conf_n);

	assign result.confirmed_preset = conf_ext[OUT_W-1:0];
	assign result.series_ended     = ended;
	assign result.series_count     = cnt_ext[OUT_W-1:0];

endmodule

// ===== rtl/pulse_series_count_confirmer.sv =====
// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+------------------------------------------
// in      | in        | in_valid / in_stall | level, time_ms, clear
// out     | out       | out_valid/out_stall | confirmed_preset, series_ended, series_count
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A sample beat is captured in an input register and evaluated against the series state in
// combinational logic. Its result is registered in the output register when that stage is free,
// and one beat can be taken every cycle unless the output stalls with both stages full. The output
// register is the stage that separates the two sides, so a waiting result does not hold up the
// next capture.
// Reset is asynchronous and active low; it empties both stages and restores state and limits.
// A stall on the output only holds the input side once both stages are full.
module pulse_series_count_confirmer #(
	parameter int COUNT_BITS = psc_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          level,
	input  logic [psc_pkg::TIME_W-1:0]    time_ms,
	input  logic                          clear,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [psc_pkg::OUT_W-1:0]     confirmed_preset,
	output logic                          series_ended,
	output logic [psc_pkg::OUT_W-1:0]     series_count,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [psc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [psc_pkg::CFG_W-1:0]     cfg_data
);
	import psc_pkg::*;

	psc_cfg_t    cfg;
	psc_item_t   item_s1;
	logic        valid_s1;
	psc_result_t result_s1;
	psc_result_t result_s2;
	logic        valid_s2;
	logic        advance;
	logic        s2_free;

	// The output stage can take a new result when it is empty or its beat leaves now.
	assign s2_free  = !valid_s2 || !out_stall;
	assign advance  = valid_s1 && s2_free;
	// The input register is free when empty or when its item moves on this cycle.
	assign in_stall = valid_s1 && !s2_free;

	psc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register: the sample is captured here before evaluation.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.level   <= level;
			item_s1.time_ms <= time_ms;
			item_s1.clear   <= clear;
		end
	end

	// The series state commits only when the evaluated sample moves into the output stage,
	// so each sample updates it exactly once.
	psc_core #(
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result_s1)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_s1;
		end
	end

	assign out_valid        = valid_s2;
	assign confirmed_preset = result_s2.confirmed_preset;
	assign series_ended     = result_s2.series_ended;
	assign series_count     = result_s2.series_count;

`ifndef ASSERT_OFF
	// A series that ends on a sample always leaves the running count at zero.
	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && series_ended |-> series_count == '0)
		else $error("series ended with a non-zero running count");

	// A clear sample that advances produces an all-zero result on the next cycle.
	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.clear |=>
		out_valid && confirmed_preset == '0 && !series_ended && series_count == '0)
		else $error("clear sample did not give an all-zero result");

	// Both stages full with the output held must push back on the input side.
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && out_stall |-> in_stall)
		else $error("input not stalled while both stages are full");

	// A result that cannot leave stays in the output register.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && out_stall |=> valid_s2 && $stable(result_s2))
		else $error("held result changed or vanished");
`endif

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the pulse series count confirmer.
//
// An initial block builds the sample stream and pushes it onto a queue of pending samples.
// A clocked driver presents those samples on the input channel and runs every accepted beat
// through a local model of the series logic. The model's outcome goes onto a queue of
// expected outcomes. A clocked monitor takes result beats off the output channel and checks
// each field against the oldest outcome in that queue.
//
// The limit registers are only written while the block holds no work. The stream covers:
//   - a short directed run at the reset limits;
//   - runs at the extreme limits;
//   - a run of more than 255 valid pulses, so the series count saturates;
//   - a run of random limits.
// Most random samples form well-formed pulse series with random widths and gaps, so series
// get counted, time out and confirm. The remainder is noise on the line and soft clears.
module tb_top;
	import psc_pkg::*;

	localparam int N_SAMPLES = 1550;
	localparam int COUNT_MAX = (1 << COUNT_BITS_DEF) - 1;
	// Index 3 is not in the register map, so a write to it must be dropped.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_stall;
	logic level = 1'b1;
	logic [TIME_W-1:0] time_ms = '0;
	logic clear = 1'b0;

	logic out_valid;
	logic out_stall = 1'b0;
	logic [OUT_W-1:0] confirmed_preset;
	logic series_ended;
	logic [OUT_W-1:0] series_count;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	pulse_series_count_confirmer u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.level            (level),
		.time_ms          (time_ms),
		.clear            (clear),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.confirmed_preset (confirmed_preset),
		.series_ended     (series_ended),
		.series_count     (series_count),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	always #5 clk = ~clk;

	// Stimulus and scoreboard storage.
	psc_item_t   pending_samples[$];
	psc_result_t expected_outcomes[$];
	int          queued_samples = 0;
	int          accepted_beats = 0;
	int          checked_beats = 0;
	int          mismatch_count = 0;
	// When this is low, neither side inserts gaps, so the block runs at full rate.
	bit          idle_en = 1'b1;
	// Running timestamp from which the pulse series are laid out.
	logic [TIME_W-1:0] t_now = '0;

	// Local copy of the limit registers and of the series state.
	psc_cfg_t          lim;
	logic              m_in_series;
	logic              m_prev_level;
	logic              m_pulse_on;
	logic [TIME_W-1:0] m_pulse_t0;
	logic [TIME_W-1:0] m_last_end;
	logic [15:0]       m_count;
	logic [15:0]       m_prev_series;
	logic [1:0]        m_match;
	logic [15:0]       m_confirmed;

	task automatic note_mismatch(input string what);
		mismatch_count++;
		$display("MISMATCH at result %0d: %s", checked_beats, what);
	endtask

	// Advances the series state by one sample and returns the outcome that the block must
	// report for it.
	task automatic step_series_model(input psc_item_t smp, output psc_result_t res);
		logic [TIME_W-1:0] width;
		logic ended;
		ended = 1'b0;
		if (smp.clear) begin
			// A soft clear drops the series and the preset, but keeps both timestamps.
			m_in_series = 1'b0;
			m_count = '0;
			m_prev_series = '0;
			m_match = '0;
			m_confirmed = '0;
			m_pulse_on = 1'b0;
			m_prev_level = smp.level;
		end else begin
			if (smp.level != m_prev_level) begin
				if (!smp.level) begin
					m_pulse_on = 1'b1;
					m_pulse_t0 = smp.time_ms;
				end else if (m_pulse_on) begin
					width = smp.time_ms - m_pulse_t0;
					if (width >= lim.min_pulse_ms && width <= lim.max_pulse_ms) begin
						if (!m_in_series) begin
							m_in_series = 1'b1;
							m_count = 16'd1;
						end else if (m_count < COUNT_MAX) begin
							m_count++;
						end
						m_last_end = smp.time_ms;
					end else begin
						m_in_series = 1'b0;
						m_count = '0;
					end
					m_pulse_on = 1'b0;
				end
				m_prev_level = smp.level;
			end
			if (m_in_series && !m_pulse_on &&
					(smp.time_ms - m_last_end) > lim.series_timeout_ms) begin
				// The series has timed out. Compare its count with the one before it.
				if (m_prev_series == '0 || m_count != m_prev_series) begin
					m_prev_series = m_count;
					m_match = 2'd1;
				end else begin
					if (m_match < MATCH_SAT)
						m_match++;
					if (m_match >= MATCH_SAT)
						m_confirmed = m_count;
				end
				m_in_series = 1'b0;
				m_count = '0;
				ended = 1'b1;
			end
		end
		res.confirmed_preset = m_confirmed[OUT_W-1:0];
		res.series_ended = ended;
		res.series_count = m_count[OUT_W-1:0];
	endtask

	// Driver. A new sample goes out once the previous one has been taken and its gap has
	// run down. The payload is held for as long as the block stalls.
	always @(posedge clk or negedge arst_n) begin : drive_samples
		psc_item_t   smp;
		psc_result_t res;
		int          gap_left;
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				smp.level = level;
				smp.time_ms = time_ms;
				smp.clear = clear;
				step_series_model(smp, res);
				expected_outcomes.push_back(res);
				accepted_beats++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					smp = pending_samples.pop_front();
					level <= smp.level;
					time_ms <= smp.time_ms;
					clear <= smp.clear;
					in_valid <= 1'b1;
					gap_left = idle_en ? $urandom_range(0, 15) : 0;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor. Each result beat is checked against the oldest expected outcome. After each
	// beat, the monitor draws a fresh stall length for the output side.
	always @(posedge clk or negedge arst_n) begin : check_results
		psc_result_t want;
		int          stall_left;
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_outcomes.size() == 0) begin
					note_mismatch("result beat with no sample outstanding");
				end else begin
					want = expected_outcomes.pop_front();
					if (confirmed_preset !== want.confirmed_preset)
						note_mismatch($sformatf("confirmed_preset got %0d expected %0d",
							confirmed_preset, want.confirmed_preset));
					if (series_ended !== want.series_ended)
						note_mismatch($sformatf("series_ended got %0b expected %0b",
							series_ended, want.series_ended));
					if (series_count !== want.series_count)
						note_mismatch($sformatf("series_count got %0d expected %0d",
							series_count, want.series_count));
				end
				checked_beats++;
				stall_left = idle_en ? $urandom_range(0, 15) : 0;
			end else if (stall_left > 0) begin
				stall_left--;
			end
			out_stall <= (stall_left != 0);
		end
	end

	task automatic queue_sample(input logic lvl, input logic [TIME_W-1:0] t, input logic clr);
		psc_item_t smp;
		smp.level = lvl;
		smp.time_ms = t;
		smp.clear = clr;
		pending_samples.push_back(smp);
		queued_samples++;
	endtask

	// Waits until every queued sample has been taken and every result checked. The short
	// tail that follows covers the block's two-stage pipeline.
	task automatic wait_until_settled();
		do
			@(posedge clk);
		while (!(accepted_beats == queued_samples && expected_outcomes.size() == 0));
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MIN_PULSE:   lim.min_pulse_ms = val;
			REG_MAX_PULSE:   lim.max_pulse_ms = val;
			REG_SER_TIMEOUT: lim.series_timeout_ms = val;
			default: ;
		endcase
	endtask

	task automatic set_limits(input int lo, input int hi, input int to);
		write_reg(REG_MIN_PULSE, lo[CFG_W-1:0]);
		write_reg(REG_MAX_PULSE, hi[CFG_W-1:0]);
		write_reg(REG_SER_TIMEOUT, to[CFG_W-1:0]);
	endtask

	// Lays out one series of low pulses, starting from the running timestamp. The widths
	// are legal unless the bad_pct draw says otherwise. The series normally closes with an
	// idle sample taken just past the timeout. Sometimes an extra sample falls exactly on
	// the timeout, and sometimes the series is left open for whatever comes next.
	task automatic queue_series(input int pulses, input int bad_pct);
		int unsigned lo;
		int unsigned hi;
		int unsigned to;
		logic [TIME_W-1:0] width;
		int p;
		lo = lim.min_pulse_ms;
		hi = lim.max_pulse_ms;
		to = lim.series_timeout_ms;
		for (p = 0; p < pulses; p++) begin
			t_now += $urandom_range(0, to);
			if ($urandom_range(0, 19) == 0)
				t_now += to + 1;
			if ($urandom_range(0, 3) == 0)
				queue_sample(1'b1, t_now, 1'b0);
			queue_sample(1'b0, t_now, 1'b0);
			if ($urandom_range(0, 99) < bad_pct) begin
				if (lo != 0 && $urandom_range(0, 1))
					width = $urandom_range(0, lo - 1);
				else
					width = hi + 1 + $urandom_range(0, 1000);
			end else if (lo <= hi) begin
				width = $urandom_range(lo, hi);
			end else begin
				width = $urandom_range(0, 400);
			end
			// While the line is held low, a repeated low sample must neither end the series
			// nor count as an edge.
			if ($urandom_range(0, 4) == 0)
				queue_sample(1'b0, t_now + width / 2, 1'b0);
			t_now += width;
			queue_sample(1'b1, t_now, 1'b0);
		end
		if ($urandom_range(0, 3) == 0)
			queue_sample(1'b1, t_now + to, 1'b0);
		if ($urandom_range(0, 9) != 0) begin
			t_now += to + 1 + $urandom_range(0, 50);
			queue_sample(1'b1, t_now, 1'b0);
		end
	endtask

	// Mostly short series, so that equal counts recur and presets get confirmed. Line noise
	// and soft clears are mixed in.
	task automatic queue_mixed(input int amount);
		int first;
		int pick;
		first = queued_samples;
		t_now = ($urandom_range(0, 2) == 0) ? 32'hFFFF_0000 + $urandom_range(0, 65535)
			: $urandom();
		while (queued_samples - first < amount) begin
			pick = $urandom_range(0, 99);
			if (pick < 75)
				queue_series(($urandom_range(0, 5) == 0) ? $urandom_range(5, 12)
					: $urandom_range(1, 3), 12);
			else if (pick < 93)
				repeat ($urandom_range(1, 6))
					queue_sample(1'($urandom_range(0, 1)), $urandom(), 1'b0);
			else
				queue_sample(1'($urandom_range(0, 1)), $urandom(), 1'b1);
		end
	endtask

	// Runs one phase of random samples. The sender is held back once in the middle until
	// every outstanding result is back, and the phase ends with the block fully drained.
	task automatic run_phase(input int amount);
		idle_en = ($urandom_range(0, 3) != 0);
		queue_mixed(amount / 2);
		wait_until_settled();
		idle_en = ($urandom_range(0, 3) != 0);
		queue_mixed(amount - amount / 2);
		wait_until_settled();
	endtask

	initial begin : stimulus
		int lo;
		lim.min_pulse_ms = RST_MIN_PULSE;
		lim.max_pulse_ms = RST_MAX_PULSE;
		lim.series_timeout_ms = RST_SER_TIMEOUT;
		m_in_series = 1'b0;
		m_prev_level = 1'b1;
		m_pulse_on = 1'b0;
		m_pulse_t0 = '0;
		m_last_end = '0;
		m_count = '0;
		m_prev_series = '0;
		m_match = '0;
		m_confirmed = '0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// The directed run uses the reset limits of 50 to 300 ms and a 2500 ms timeout.
		queue_sample(1'b1, 32'hFFFF_FFFF, 1'b0);  // idle high, all-ones time
		queue_sample(1'b0, 32'h0, 1'b1);          // clear while low
		queue_sample(1'b1, 32'd5, 1'b0);          // rising edge with no pulse open
		// First series: the first pulse straddles the timestamp wrap, the next two pulses
		// sit exactly on the lower and upper width bounds.
		queue_sample(1'b0, 32'hFFFF_FFF0, 1'b0);
		queue_sample(1'b1, 32'h0000_0030, 1'b0);
		queue_sample(1'b0, 32'h100, 1'b0);
		queue_sample(1'b1, 32'h100 + 50, 1'b0);
		queue_sample(1'b0, 32'h200, 1'b0);
		queue_sample(1'b1, 32'h200 + 300, 1'b0);
		queue_sample(1'b1, 32'h200 + 300 + 2500, 1'b0);  // on the timeout, still open
		queue_sample(1'b1, 32'h200 + 300 + 2501, 1'b0);  // past it, series of three ends
		// Pulses one short of the minimum and one past the maximum, seen while idle.
		queue_sample(1'b0, 32'h1000, 1'b0);
		queue_sample(1'b1, 32'h1000 + 49, 1'b0);
		queue_sample(1'b0, 32'h2000, 1'b0);
		queue_sample(1'b1, 32'h2000 + 301, 1'b0);
		// A second series of three, which confirms the preset.
		queue_sample(1'b0, 32'h3000, 1'b0);
		queue_sample(1'b1, 32'h3000 + 100, 1'b0);
		queue_sample(1'b0, 32'h3200, 1'b0);
		queue_sample(1'b1, 32'h3200 + 100, 1'b0);
		queue_sample(1'b0, 32'h3400, 1'b0);
		queue_sample(1'b1, 32'h3400 + 100, 1'b0);
		queue_sample(1'b1, 32'h4000 + 2600, 1'b0);
		queue_sample(1'b1, 32'h5000, 1'b1);       // clear drops the preset
		queue_sample(1'b0, 32'h6000, 1'b0);
		queue_sample(1'b1, 32'h6000 + 100, 1'b0);
		wait_until_settled();

		// Widest window and a zero timeout, so any idle sample after the last pulse end closes a series.
		set_limits(0, 65535, 0);
		run_phase(150);

		// Minimum above maximum: no pulse width is valid.
		set_limits(65535, 0, 65535);
		run_phase(100);

		// More than 255 back-to-back valid pulses push the count into saturation.
		set_limits(0, 65535, 65535);
		idle_en = ($urandom_range(0, 1) != 0);
		t_now = $urandom();
		queue_series(260, 0);
		t_now += 32'd70000;
		queue_sample(1'b1, t_now, 1'b0);
		wait_until_settled();

		// A write to an index outside the map must leave the limits unchanged.
		write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 65535)));
		run_phase(60);

		while (queued_samples < N_SAMPLES) begin
			lo = $urandom_range(0, 400);
			case ($urandom_range(0, 3))
				0: set_limits(lo, lo, $urandom_range(0, 200));
				1: set_limits(lo, lo + $urandom_range(0, 600), 65535);
				default: set_limits(lo, lo + $urandom_range(0, 600), $urandom_range(50, 4000));
			endcase
			run_phase(150);
		end

		wait_until_settled();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("pulse_series_count_confirmer verification clean");
		end else begin
			$display("pulse_series_count_confirmer verification failed");
		end
		$finish;
	end

	// Watchdog. A correct run finishes well inside this limit, even with every gap and
	// every stall at its longest.
	initial begin : watchdog
		#5_000_000;
		$display("pulse_series_count_confirmer verification failed");
		$finish;
	end

endmodule

// ===== pulse_series_count_confirmer.f =====
rtl/psc_pkg.sv
rtl/psc_cfg.sv
rtl/psc_core.sv
rtl/pulse_series_count_confirmer.sv
sim/tb_top.sv
